### rtl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the two-way sorted merge block.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int VALUE_BITS  = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ELEM_FIRST  = 2'd0,
    REQ_ELEM_SECOND = 2'd1,
    REQ_END_FIRST   = 2'd2,
    REQ_END_SECOND  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_ENDED = 2'd2
  } status_t;

  typedef struct packed {
    logic                         sel_second;
    logic                         is_end;
    logic signed [VALUE_BITS-1:0] value;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### rtl/tsm_front.sv
// ----------------------------------------------------------------------------
// tsm_front
// Accepts input transfers, decodes the request kind and holds the decoded
// commands in a two-entry queue for the merge engine.
// ----------------------------------------------------------------------------
module tsm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // value
  input  logic [1:0]    in_tuser,   // req_type
  output logic          cmd_valid,
  output tsm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tsm_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.value      = VALUE_BITS'($signed(in_tdata));
    dec.sel_second = 1'b0;
    dec.is_end     = 1'b0;
    unique case (req_type_t'(in_tuser))
      REQ_ELEM_FIRST: begin
        dec.sel_second = 1'b0;
        dec.is_end     = 1'b0;
      end
      REQ_ELEM_SECOND: begin
        dec.sel_second = 1'b1;
        dec.is_end     = 1'b0;
      end
      REQ_END_FIRST: begin
        dec.sel_second = 1'b0;
        dec.is_end     = 1'b1;
      end
      REQ_END_SECOND: begin
        dec.sel_second = 1'b1;
        dec.is_end     = 1'b1;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = cmd_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/tsm_back.sv
// ----------------------------------------------------------------------------
// tsm_back
// Merge engine: keeps the two sequence queues in memories, checks each
// command, and emits the smaller head while a choice can be made.
// ----------------------------------------------------------------------------
module tsm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wen,
  input  logic          cfg_wdata,
  input  logic          cmd_valid,
  input  tsm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,  // merged_value, merge_end, zero pad
  output logic [2:0]    out_tuser,  // has_value, status
  output logic          out_tlast   // run_last
);
  import tsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FETCH  = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  logic signed [VALUE_BITS-1:0] mem_fst [QUEUE_DEPTH];
  logic signed [VALUE_BITS-1:0] mem_snd [QUEUE_DEPTH];
  logic signed [VALUE_BITS-1:0] rdata_fst_r, rdata_snd_r;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wr_fst_r, wr_fst_nxt, rd_fst_r, rd_fst_nxt;
  logic [PTR_W-1:0] wr_snd_r, wr_snd_nxt, rd_snd_r, rd_snd_nxt;
  logic [CNT_W-1:0] cnt_fst_r, cnt_fst_nxt, cnt_snd_r, cnt_snd_nxt;
  logic             end_fst_r, end_fst_nxt, end_snd_r, end_snd_nxt;
  logic             tie_r;
  logic             wen_fst, wen_snd;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                         out_has_r, out_has_nxt;
  logic                         out_end_r, out_end_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_load, out_free;

  // merge decision on the registered heads
  logic             has_fst, has_snd, can_choose, take_fst;
  logic [CNT_W-1:0] cnt_fst_pop, cnt_snd_pop;
  logic             fin_pop, end_fst_pop, end_snd_pop, more;
  logic             sel_ended, sel_full;

  assign out_free = !out_valid_r || out_tready;

  assign has_fst    = (cnt_fst_r != '0);
  assign has_snd    = (cnt_snd_r != '0);
  assign can_choose = (has_fst && has_snd) || (has_fst && end_snd_r) ||
                      (has_snd && end_fst_r);
  assign take_fst   = (has_fst && has_snd) ?
                      ((rdata_fst_r < rdata_snd_r) ||
                       ((rdata_fst_r == rdata_snd_r) && tie_r)) : has_fst;
  assign cnt_fst_pop = cnt_fst_r - CNT_W'(take_fst);
  assign cnt_snd_pop = cnt_snd_r - CNT_W'(!take_fst);
  assign fin_pop     = end_fst_r && end_snd_r &&
                       (cnt_fst_pop == '0) && (cnt_snd_pop == '0);
  assign end_fst_pop = end_fst_r && !fin_pop;
  assign end_snd_pop = end_snd_r && !fin_pop;
  assign more        = ((cnt_fst_pop != '0) && (cnt_snd_pop != '0)) ||
                       ((cnt_fst_pop != '0) && end_snd_pop) ||
                       ((cnt_snd_pop != '0) && end_fst_pop);

  assign sel_ended = cmd.sel_second ? end_snd_r : end_fst_r;
  assign sel_full  = (cmd.sel_second ? cnt_snd_r : cnt_fst_r) == CNT_W'(QUEUE_DEPTH);

  always_comb begin
    state_nxt      = state_r;
    wr_fst_nxt     = wr_fst_r;
    rd_fst_nxt     = rd_fst_r;
    wr_snd_nxt     = wr_snd_r;
    rd_snd_nxt     = rd_snd_r;
    cnt_fst_nxt    = cnt_fst_r;
    cnt_snd_nxt    = cnt_snd_r;
    end_fst_nxt    = end_fst_r;
    end_snd_nxt    = end_snd_r;
    wen_fst        = 1'b0;
    wen_snd        = 1'b0;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;
    out_value_nxt  = out_value_r;
    out_has_nxt    = out_has_r;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.is_end) begin
            if (cmd.sel_second) begin
              end_snd_nxt = 1'b1;
            end else begin
              end_fst_nxt = 1'b1;
            end
            state_nxt = S_FETCH;
          end else if (sel_ended || sel_full) begin
            out_load       = 1'b1;
            out_value_nxt  = '0;
            out_has_nxt    = 1'b0;
            out_end_nxt    = 1'b0;
            out_status_nxt = sel_ended ? STATUS_ENDED : STATUS_FULL;
            out_last_nxt   = 1'b1;
          end else begin
            if (cmd.sel_second) begin
              wen_snd     = 1'b1;
              wr_snd_nxt  = ptr_inc(wr_snd_r);
              cnt_snd_nxt = cnt_snd_r + 1'b1;
            end else begin
              wen_fst     = 1'b1;
              wr_fst_nxt  = ptr_inc(wr_fst_r);
              cnt_fst_nxt = cnt_fst_r + 1'b1;
            end
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          if (can_choose) begin
            if (take_fst) begin
              rd_fst_nxt = ptr_inc(rd_fst_r);
            end else begin
              rd_snd_nxt = ptr_inc(rd_snd_r);
            end
            cnt_fst_nxt    = cnt_fst_pop;
            cnt_snd_nxt    = cnt_snd_pop;
            end_fst_nxt    = end_fst_pop;
            end_snd_nxt    = end_snd_pop;
            out_load       = 1'b1;
            out_value_nxt  = take_fst ? rdata_fst_r : rdata_snd_r;
            out_has_nxt    = 1'b1;
            out_end_nxt    = fin_pop;
            out_status_nxt = STATUS_OK;
            out_last_nxt   = !more;
            state_nxt      = more ? S_FETCH : S_IDLE;
          end else begin
            if (end_fst_r && end_snd_r && !has_fst && !has_snd) begin
              // both sequences empty: end result without a value
              end_fst_nxt    = 1'b0;
              end_snd_nxt    = 1'b0;
              out_load       = 1'b1;
              out_value_nxt  = '0;
              out_has_nxt    = 1'b0;
              out_end_nxt    = 1'b1;
              out_status_nxt = STATUS_OK;
              out_last_nxt   = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wen_fst) begin
      mem_fst[wr_fst_r] <= cmd.value;
    end
    if (wen_snd) begin
      mem_snd[wr_snd_r] <= cmd.value;
    end
    rdata_fst_r <= mem_fst[rd_fst_r];
    rdata_snd_r <= mem_snd[rd_snd_r];
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_has_r    <= out_has_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_fst_r    <= '0;
      rd_fst_r    <= '0;
      wr_snd_r    <= '0;
      rd_snd_r    <= '0;
      cnt_fst_r   <= '0;
      cnt_snd_r   <= '0;
      end_fst_r   <= 1'b0;
      end_snd_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tie_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_fst_r    <= wr_fst_nxt;
      rd_fst_r    <= rd_fst_nxt;
      wr_snd_r    <= wr_snd_nxt;
      rd_snd_r    <= rd_snd_nxt;
      cnt_fst_r   <= cnt_fst_nxt;
      cnt_snd_r   <= cnt_snd_nxt;
      end_fst_r   <= end_fst_nxt;
      end_snd_r   <= end_snd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        tie_r <= cfg_wdata;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_end_r, 32'(out_value_r)};
  assign out_tuser  = {out_status_r, out_has_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/two_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// Merges two tagged ascending sequences of signed values into one ascending
// stream, with a selectable tie rule and drop status for bad elements.
// ----------------------------------------------------------------------------
// an input transfer goes through the input queue, the command check and the head
// read before its first result; the engine takes the next command only once the
//   run is over, each merged result waiting on a registered head read before its compare
// dropped elements skip the head read; the input queue takes items while results wait
// reset: counts, ended flags and tie rule cleared; queue memories are not cleared
module two_way_sorted_merge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,   // tie_takes_first
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // value
  input  logic [1:0]  in_tuser,    // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // merged_value, merge_end, zero pad
  output logic [2:0]  out_tuser,   // has_value, status
  output logic        out_tlast    // run_last
);
  import tsm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  tsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/two_way_sorted_merge_test.sv
// ----------------------------------------------------------------------------
// two_way_sorted_merge_test
// Self-checking bench for the two-way sorted merge. Tagged elements and end
// markers go in on the input stream; a behavioural model of both queues, the
// end flags and the tie rule predicts every merged and status result, and
// each output transfer is checked field by field against it. Directed cases
// come first, then random merges under changing idle patterns and tie rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_way_sorted_merge_test;
  import tsm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [31:0] value;
    logic               has_value;
    logic               merge_end;
    status_t            status;
    logic               run_last;
  } merge_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = REQ_ELEM_FIRST;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;   // merged_value, merge_end, zero pad
  logic [2:0]  out_tuser;   // has_value, status
  logic        out_tlast;   // run_last

  // merge model state
  logic signed [31:0] first_pending[$];
  logic signed [31:0] second_pending[$];
  logic               first_ended  = 1'b0;
  logic               second_ended = 1'b0;
  logic               tie_first    = 1'b0;
  merge_result_t      merge_expected[$];

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_left     = 0;
  int cycles        = 0;
  int fail_count    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int merges_done   = 0;
  int status_seen   = 0;

  two_way_sorted_merge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               merge_expected.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: long hold-off when asked, otherwise random idling
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void push_result(logic signed [31:0] v, logic has,
                                      logic ends, status_t st);
    merge_result_t r;
    r.value     = has ? v : '0;
    r.has_value = has;
    r.merge_end = ends;
    r.status    = st;
    r.run_last  = 1'b0;
    merge_expected.push_back(r);
  endfunction

  function automatic logic merge_complete();
    return first_ended && second_ended && first_pending.size() == 0 &&
           second_pending.size() == 0;
  endfunction

  function automatic void close_merge();
    first_ended  = 1'b0;
    second_ended = 1'b0;
    merges_done++;
  endfunction

  function automatic void predict_merge(req_type_t kind, logic signed [31:0] value);
    int                 n;
    logic               own_ended;
    int                 own_count;
    logic               take_first;
    logic signed [31:0] e;
    n = 0;
    if (kind == REQ_ELEM_FIRST || kind == REQ_ELEM_SECOND) begin
      own_ended = (kind == REQ_ELEM_FIRST) ? first_ended : second_ended;
      own_count = (kind == REQ_ELEM_FIRST) ? first_pending.size() :
                                             second_pending.size();
      if (own_ended) begin
        push_result('0, 1'b0, 1'b0, STATUS_ENDED);
        n++;
      end else if (own_count >= QUEUE_DEPTH) begin
        push_result('0, 1'b0, 1'b0, STATUS_FULL);
        n++;
      end else if (kind == REQ_ELEM_FIRST) begin
        first_pending.push_back(value);
      end else begin
        second_pending.push_back(value);
      end
    end else if (kind == REQ_END_FIRST) begin
      first_ended = 1'b1;
    end else begin
      second_ended = 1'b1;
    end

    while (n < 2 * QUEUE_DEPTH + 1) begin
      if (first_pending.size() > 0 && second_pending.size() > 0) begin
        if (first_pending[0] < second_pending[0])
          take_first = 1'b1;
        else if (second_pending[0] < first_pending[0])
          take_first = 1'b0;
        else
          take_first = tie_first;
      end else if (first_pending.size() > 0 && second_ended) begin
        take_first = 1'b1;
      end else if (second_pending.size() > 0 && first_ended) begin
        take_first = 1'b0;
      end else begin
        break;
      end
      e = take_first ? first_pending.pop_front() : second_pending.pop_front();
      if (merge_complete()) begin
        push_result(e, 1'b1, 1'b1, STATUS_OK);
        close_merge();
      end else begin
        push_result(e, 1'b1, 1'b0, STATUS_OK);
      end
      n++;
    end

    if (merge_complete()) begin
      push_result('0, 1'b0, 1'b1, STATUS_OK);
      close_merge();
      n++;
    end
    if (n > 0)
      merge_expected[merge_expected.size() - 1].run_last = 1'b1;
  endfunction

  always @(posedge clk) begin
    merge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (merge_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %0d tdata %h tuser %b last %b",
                   $signed(out_tdata[31:0]), out_tdata, out_tuser, out_tlast);
      end else begin
        want = merge_expected.pop_front();
        if (want.status != STATUS_OK)
          status_seen++;
        if (out_tdata[31:0] !== want.value || out_tuser[0] !== want.has_value ||
            out_tdata[32] !== want.merge_end || out_tuser[2:1] !== want.status ||
            out_tlast !== want.run_last) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch at result %0d: expected value %0d has %b end %b",
                      " status %0d last %b, got value %0d has %b end %b",
                      " status %0d last %b"},
                     results_seen, want.value, want.has_value, want.merge_end,
                     want.status, want.run_last, $signed(out_tdata[31:0]),
                     out_tuser[0], out_tdata[32], out_tuser[2:1], out_tlast);
        end
      end
    end
  end

  task automatic send_item(req_type_t kind, logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict_merge(kind, value);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (merge_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tie(logic v);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tie_first = v;
    cfg_wen   <= 1'b0;
  endtask

  function automatic void fill_sorted(output logic signed [31:0] vals[$], input int len);
    int                 mode;
    logic signed [31:0] base;
    mode = $urandom_range(3);
    base = $urandom;
    vals = {};
    repeat (len) begin
      case (mode)
        0: vals.push_back($urandom);
        1: vals.push_back($signed($urandom_range(12)) - 6);
        2: vals.push_back(base + $signed($urandom_range(2000)) - 1000);
        default: begin
          case ($urandom_range(2))
            0: vals.push_back(32'sh8000_0000);
            1: vals.push_back(32'sh7fff_ffff);
            default: vals.push_back($urandom);
          endcase
        end
      endcase
    end
    vals.sort();
  endfunction

  // one merge with random content, some noise and broken ordering of markers
  task automatic run_random_merge();
    logic signed [31:0] a_vals[$];
    logic signed [31:0] b_vals[$];
    int                 ia;
    int                 ib;
    bit                 a_done;
    bit                 b_done;
    bit                 pick_a;
    fill_sorted(a_vals, ($urandom_range(9) == 0) ? $urandom_range(30, 36) :
                                                   $urandom_range(10));
    fill_sorted(b_vals, ($urandom_range(9) == 0) ? $urandom_range(30, 36) :
                                                   $urandom_range(10));
    ia = 0;
    ib = 0;
    a_done = 0;
    b_done = 0;
    while (!(a_done && b_done)) begin
      if ($urandom_range(99) < 6) begin
        send_item(req_type_t'($urandom_range(3)), $urandom);
      end else begin
        pick_a = !a_done && (b_done || $urandom_range(1));
        if (pick_a) begin
          if (ia < a_vals.size()) begin
            send_item(REQ_ELEM_FIRST, a_vals[ia]);
            ia++;
          end else begin
            send_item(REQ_END_FIRST, $urandom);
            a_done = 1;
            if ($urandom_range(7) == 0)
              send_item(REQ_END_FIRST, $urandom);
            if ($urandom_range(5) == 0)
              send_item(REQ_ELEM_FIRST, $urandom);
          end
        end else begin
          if (ib < b_vals.size()) begin
            send_item(REQ_ELEM_SECOND, b_vals[ib]);
            ib++;
          end else begin
            send_item(REQ_END_SECOND, $urandom);
            b_done = 1;
            if ($urandom_range(7) == 0)
              send_item(REQ_END_SECOND, $urandom);
            if ($urandom_range(5) == 0)
              send_item(REQ_ELEM_SECOND, $urandom);
          end
        end
      end
    end
  endtask

  task automatic test_basic_merge();
    send_item(REQ_ELEM_FIRST, 32'h8000_0000);
    send_item(REQ_ELEM_SECOND, 32'd5);
    send_item(REQ_ELEM_FIRST, 32'd5);
    send_item(REQ_ELEM_FIRST, 32'd5);
    send_item(REQ_ELEM_SECOND, 32'h7fff_ffff);
    send_item(REQ_END_FIRST, 32'hffff_ffff);
    send_item(REQ_END_SECOND, 32'h0);
    settle();
  endtask

  task automatic test_tie_rule();
    write_tie(1'b1);
    send_item(REQ_ELEM_SECOND, 32'd3);
    send_item(REQ_ELEM_FIRST, 32'd3);
    send_item(REQ_ELEM_FIRST, 32'd3);
    send_item(REQ_END_SECOND, 32'h0);
    send_item(REQ_END_FIRST, 32'h0);
    write_tie(1'b0);
  endtask

  task automatic test_empty_merge();
    send_item(REQ_END_FIRST, 32'h0);
    send_item(REQ_END_FIRST, 32'h5555_aaaa);
    send_item(REQ_END_SECOND, 32'h0);
    settle();
  endtask

  task automatic test_element_after_end();
    send_item(REQ_END_SECOND, 32'h0);
    send_item(REQ_ELEM_SECOND, 32'd42);
    send_item(REQ_ELEM_FIRST, 32'hffff_ffff);
    send_item(REQ_END_FIRST, 32'h0);
    settle();
  endtask

  // overflow one queue, then release all of it in one run once the other sequence ends
  task automatic test_full_queue();
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_item(REQ_ELEM_FIRST, 32'(i * 3 - 40));
    send_item(REQ_END_SECOND, 32'h0);
    send_item(REQ_END_FIRST, 32'h0);
    settle();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_left = 400;
    for (int i = 0; i < 30; i++) begin
      send_item(REQ_ELEM_FIRST, 32'(4 * i - 50));
      send_item(REQ_ELEM_SECOND, 32'(4 * i - 48));
    end
    send_item(REQ_END_FIRST, 32'h0);
    send_item(REQ_END_SECOND, 32'h0);
    settle();
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct, int goal);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < goal)
      run_random_merge();
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 19;
    rx_idle_pct = 56;
    test_basic_merge();
    test_tie_rule();
    test_empty_merge();
    test_element_after_end();
    test_full_queue();
    test_backpressure();
    write_tie(1'b1);
    run_random_phase(19, 56, 45);
    write_tie(1'b0);
    run_random_phase(56, 19, 45);
    write_tie(1'b1);
    run_random_phase(0, 0, 45);
    settle();
    $display("run covered %0d input transfers, %0d result transfers (%0d with status)",
             items_sent, results_seen, status_seen);
    $display("%0d merges completed under both tie rules, %0d mismatches",
             merges_done, fail_count);
    if (fail_count == 0 && merge_expected.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
